// ----- hdl/ftm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared constants for the filmic tone map pixel pipeline.
// ----------------------------------------------------------------------------
package ftm_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned ChanW     = 24;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned LineW     = 13;
  localparam int unsigned OffW      = 26;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned QBits     = 8;

  // Doubled channel below white point fits FracBits+1 bits
  localparam int unsigned YW        = FracBits + 1;
  localparam int unsigned Y2W       = 2 * YW;
  localparam int unsigned NumW      = Y2W + 8;
  localparam int unsigned DenW      = Y2W + 8;
  localparam int unsigned RemW      = NumW + 15;
  localparam int unsigned DivW      = DenW + 7;

  // Curve coefficients after clearing fractions
  localparam int unsigned KNumSq    = 210;
  localparam int unsigned KNumLin   = 25;
  localparam int unsigned KDenSq    = 75;
  localparam int unsigned KDenLin   = 250;
  localparam int unsigned KDenConst = 30;
  localparam int unsigned KScaleNum = 21165;
  localparam int unsigned KScaleDen = 89;

  localparam logic [LineW-1:0] LineWidthReset = LineW'(640);

  localparam int unsigned CurveStages = 4;
  localparam int unsigned NumStages   = CurveStages + QBits;

endpackage

// ----- hdl/filmic_tone_map_pixel_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filmic_tone_map_pixel_top
// Filmic tone mapping of an HDR pixel stream with frame buffer addressing.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel (column, row, three Q8.16 channels)
//   and leave on the m_axis channel (RGB byte offset, three mapped bytes).
//   cfg_we_i writes the line width from cfg_data_i; write it only while no
//   pixel is in flight.
//   Twelve register stages lie between input and output: input, square,
//   polynomials, scaling, then one per quotient bit in an eight stage
//   divider, the first of them loaded by the accepting edge itself.
//   Throughput is one pixel per cycle; every stage is a register with its
//   own valid bit, so a new pixel enters each cycle the stream flows.
//   When the receiver stalls, each stage holds only if the stage after it
//   is occupied, so bubbles close up and up to 12 pixels are held before
//   s_axis_tready_o drops. Nothing is lost or repeated.
//   Reset clears all valid bits and sets the line width to 640.
// ----------------------------------------------------------------------------
module filmic_tone_map_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // column[11:0], row[23:12], red_in[47:24], green_in[71:48], blue_in[95:72]
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // byte_offset[25:0], red_byte[33:26], green_byte[41:34], blue_byte[49:42]
  output logic [55:0] m_axis_tdata_o
);
  import ftm_pkg::*;

  logic [LineW-1:0]     line_width_q;
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  logic [OffW-1:0]      off_q [NumStages];
  logic [ByteW-1:0]     red_byte, green_byte, blue_byte;

  // Line width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_data_i;
    end
  end

  // Stage enables: load when empty or when the next stage drains
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Offset: row times width plus column, then times three, then delay
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      off_q[0] <= OffW'(OffW'(s_axis_tdata_i[23:12]) * OffW'(line_width_q))
                + OffW'(s_axis_tdata_i[11:0]);
    end
    if (en[1]) begin
      off_q[1] <= OffW'(off_q[0] + (off_q[0] << 1));
    end
    for (int k = 2; k < NumStages; k++) begin
      if (en[k]) begin
        off_q[k] <= off_q[k-1];
      end
    end
  end

  ftm_channel u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (s_axis_tdata_i[47:24]),
    .byte_o (red_byte)
  );

  ftm_channel u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (s_axis_tdata_i[71:48]),
    .byte_o (green_byte)
  );

  ftm_channel u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .chan_i (s_axis_tdata_i[95:72]),
    .byte_o (blue_byte)
  );

  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tdata_o  = {6'd0, blue_byte, green_byte, red_byte, off_q[NumStages-1]};

`ifndef SYNTH
  // A ready receiver never stalls the source
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  // Backpressure at the input only when the pipeline is full to the output
  a_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && valid_q[0]))
    else $error("input stalled with empty stages");

  // Output valid comes only from a pixel accepted earlier
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0) |=> !m_axis_tvalid_o)
    else $error("output valid without pixel in flight");
`endif

endmodule

// ----- hdl/ftm_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_div_stage
// One restoring division step: resolves a single quotient bit.
// ----------------------------------------------------------------------------
module ftm_div_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ftm_pkg::RemW-1:0]    rem_i,
  input  logic [ftm_pkg::DivW-1:0]    div_i,
  input  logic [ftm_pkg::QBits-1:0]   quo_i,
  output logic [ftm_pkg::RemW-1:0]    rem_o,
  output logic [ftm_pkg::DivW-1:0]    div_o,
  output logic [ftm_pkg::QBits-1:0]   quo_o
);
  import ftm_pkg::*;

  logic [RemW-1:0]  shifted;
  logic             take;
  logic [RemW-1:0]  rem_d, rem_q;
  logic [DivW-1:0]  div_q;
  logic [QBits-1:0] quo_d, quo_q;

  // Compare remainder with the shifted divisor and subtract on success
  always_comb begin
    shifted = RemW'(div_i) << Bit;
    take    = (rem_i >= shifted);
    rem_d   = take ? (rem_i - shifted) : rem_i;
    quo_d   = quo_i;
    if (take) begin
      quo_d[Bit] = 1'b1;
    end
  end

  // Hold while the next stage is blocked
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;

endmodule

// ----- hdl/ftm_channel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_channel
// Filmic curve of one color channel: curve terms over four stages, then an
// eight stage divider that yields the output byte.
// ----------------------------------------------------------------------------
module ftm_channel (
  input  logic                             clk_i,
  input  logic [ftm_pkg::NumStages-1:0]    en_i,
  input  logic [ftm_pkg::ChanW-1:0]        chan_i,
  output logic [ftm_pkg::ByteW-1:0]        byte_o
);
  import ftm_pkg::*;

  logic [YW-1:0]   y_q;
  logic            sat0_q, sat1_q, sat2_q;
  logic [YW-1:0]   y1_q;
  logic [Y2W-1:0]  y2_q;
  logic [NumW-1:0] num_d, num_q;
  logic [DenW-1:0] den_d, den_q;
  logic [RemW-1:0] rem_q;
  logic [DivW-1:0] div_q;

  logic [RemW-1:0]  rem_c [QBits+1];
  logic [DivW-1:0]  div_c [QBits+1];
  logic [QBits-1:0] quo_c [QBits+1];

  // Stage 0: double the channel, flag white point and above
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sat0_q <= (chan_i[ChanW-1:FracBits] != '0);
      y_q    <= {chan_i[FracBits-1:0], 1'b0};
    end
  end

  // Stage 1: square
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sat1_q <= sat0_q;
      y1_q   <= y_q;
      y2_q   <= Y2W'(y_q) * Y2W'(y_q);
    end
  end

  // Stage 2: numerator and denominator polynomials
  always_comb begin
    num_d = NumW'(y2_q) * NumW'(KNumSq)
          + ((NumW'(y1_q) * NumW'(KNumLin)) << FracBits);
    den_d = DenW'(y2_q) * DenW'(KDenSq)
          + ((DenW'(y1_q) * DenW'(KDenLin)) << FracBits)
          + (DenW'(KDenConst) << (2 * FracBits));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sat2_q <= sat1_q;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  // Stage 3: scale; a zero divisor forces every quotient bit for saturation
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rem_q <= RemW'(num_q) * RemW'(KScaleNum);
      div_q <= sat2_q ? '0 : DivW'(den_q) * DivW'(KScaleDen);
    end
  end

  assign rem_c[0] = rem_q;
  assign div_c[0] = div_q;
  assign quo_c[0] = '0;

  // Divider: most significant quotient bit first
  for (genvar j = 0; j < QBits; j++) begin : g_div
    ftm_div_stage #(
      .Bit (QBits - 1 - j)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en_i[CurveStages + j]),
      .rem_i (rem_c[j]),
      .div_i (div_c[j]),
      .quo_i (quo_c[j]),
      .rem_o (rem_c[j+1]),
      .div_o (div_c[j+1]),
      .quo_o (quo_c[j+1])
    );
  end

  assign byte_o = quo_c[QBits];

endmodule

// ----- tb/ftm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_checker
// Watches both pixel channels, predicts each mapped pixel from the accepted
// input and the current line width, and compares results in order.
// ----------------------------------------------------------------------------
module ftm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ftm_pkg::LineW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid_i,
  input  logic                      s_axis_tready_i,
  input  logic [95:0]               s_axis_tdata_i,
  input  logic                      m_axis_tvalid_i,
  input  logic                      m_axis_tready_i,
  input  logic [55:0]               m_axis_tdata_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        pixels_o
);
  import ftm_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
    logic [OffW-1:0]  offset;
  } mapped_px_t;

  logic [LineW-1:0] width_q;
  mapped_px_t       mapped_q[$];

  // Exact curve: largest r with 89*r*den <= 21165*num, saturated to 255
  function automatic logic [7:0] map_channel(logic [ChanW-1:0] raw);
    logic [127:0] s, y, num, den, lhs, rhs;
    logic [8:0]   r;
    s = 128'(1) << FracBits;
    y = 128'(raw) * 2;
    if (y >= 2 * s) return 8'd255;
    num = y * (210 * y + 25 * s);
    den = 75 * y * y + 250 * y * s + 30 * s * s;
    rhs = 21165 * num;
    r = 0;
    for (int b = 7; b >= 0; b--) begin
      lhs = (r | (9'd1 << b)) * 89 * den;
      if (lhs <= rhs) r = r | (9'd1 << b);
    end
    return r[7:0];
  endfunction

  function automatic mapped_px_t map_pixel(logic [95:0] d, logic [LineW-1:0] w);
    mapped_px_t p;
    logic [63:0] off;
    off = (64'(d[11:0]) + 64'(d[23:12]) * 64'(w)) * 3;
    p.offset = off[OffW-1:0];
    p.red    = map_channel(d[47:24]);
    p.green  = map_channel(d[71:48]);
    p.blue   = map_channel(d[95:72]);
    return p;
  endfunction

  assign pending_o = mapped_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    mapped_px_t exp_px, got;
    if (!rst_ni) begin
      width_q   <= LineWidthReset;
      errors_o  <= 0;
      pixels_o  <= 0;
      mapped_q.delete();
    end else begin
      if (cfg_we_i) width_q <= cfg_data_i;
      // predict each accepted pixel
      if (s_axis_tvalid_i && s_axis_tready_i)
        mapped_q.push_back(map_pixel(s_axis_tdata_i, width_q));
      // compare each result transfer with the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[49:0];
        pixels_o <= pixels_o + 1;
        if (mapped_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected result %h", got);
          errors_o <= errors_o + 1;
        end else begin
          exp_px = mapped_q.pop_front();
          if (got !== exp_px || m_axis_tdata_i[55:50] !== 6'd0) begin
            if (errors_o < 10)
              $display("ERROR: off %0d/%0d r %0d/%0d g %0d/%0d b %0d/%0d (exp/got)",
                       exp_px.offset, got.offset, exp_px.red, got.red,
                       exp_px.green, got.green, exp_px.blue, got.blue);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random pixels with random gaps and stalls through the
// tone map block under several line widths; the checker scores results.
// ----------------------------------------------------------------------------
module tb;
  import ftm_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  int          errors, pending, pixels;
  int          cycles = 0;
  bit          sink_run = 1'b0;

  always #5 clk_i = ~clk_i;

  filmic_tone_map_pixel_top DUT (.*);

  ftm_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .errors_o(errors), .pending_o(pending), .pixels_o(pixels)
  );

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Channel value spread: edges, near white point, anywhere
  function automatic logic [23:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 255));
      1: return 24'(24'h010000 + $urandom_range(0, 511) - 256);
      2: return 24'(24'hFFFFFF - $urandom_range(0, 255));
      3: return 24'($urandom_range(0, 24'h00FFFF));
      default: return 24'($urandom());
    endcase
  endfunction

  // Stall the receiver at random, with quiet stretches
  always @(posedge clk_i) begin
    if (sink_run) m_axis_tready_i <= ($urandom_range(0, 99) < 5) ? 1'b1 :
                                     (gap_len() == 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Keep valid high across back to back transfers; drop it only for a gap
  task automatic send_pixel(logic [95:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_width(logic [12:0] w);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic pixel_run(int n);
    for (int i = 0; i < n; i++) begin
      send_pixel({rand_chan(), rand_chan(), rand_chan(),
                  12'($urandom()), 12'($urandom())});
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    logic [12:0] widths[6];
    widths = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd1920, 13'd640};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_run = 1'b1;
    @(posedge clk_i);
    // directed: reset width, coordinate and channel extremes
    send_pixel('0);
    send_pixel({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF});
    send_pixel({24'h010000, 24'h00FFFF, 24'h00FFFE, 12'h0, 12'hFFF});
    send_pixel({24'h000001, 24'h008000, 24'h010001, 12'hFFF, 12'h0});
    send_pixel({24'h555555, 24'hAAAAAA, 24'h000002, 12'h555, 12'hAAA});
    send_pixel({24'h004000, 24'h002000, 24'h00C000, 12'h001, 12'h001});
    drain();
    // random phases across line widths
    foreach (widths[k]) begin
      write_width(widths[k]);
      pixel_run(215);
      drain();
    end
    $display("Covered %0d pixels over six line widths incl. 0, 1, 4096, 8191,", pixels);
    $display("with channel values around zero, white point and full scale.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filmic_tone_map_pixel_top.f -----
hdl/ftm_pkg.sv
hdl/ftm_div_stage.sv
hdl/ftm_channel.sv
hdl/filmic_tone_map_pixel_top.sv
tb/ftm_checker.sv
tb/tb.sv
